// ----- rtl/eec_pkg.sv -----
// Shared types, constants and tables for the elastic easing curve pipeline.
package eec_pkg;

  // Field widths
  localparam int TIME_BITS = 16;
  localparam int FRAC_BITS = 16;
  localparam int ELAPSED_W = 16;
  localparam int VALUE_W   = 18;
  localparam int Q_SHIFT   = 30;

  // Series lengths
  localparam int EXP_TERMS  = 14;
  localparam int TRIG_TERMS = 10;

  // Widths of the series products carried down the chain
  localparam int EP_W = 31;
  localparam int TP_W = 34;

  // Q30 constants
  localparam logic [31:0] Q30_ONE    = 32'h4000_0000;
  localparam logic [29:0] LN2_Q30    = 30'd744261118;
  localparam logic [30:0] HALFPI_Q30 = 31'd1686629713;

  // Curve modes; any other code runs as ease-in-out
  localparam logic [1:0] CURVE_IN  = 2'd0;
  localparam logic [1:0] CURVE_OUT = 2'd1;

  // Register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION   = 2'd1;

  // Reciprocals for the phase division by three or nine
  localparam int PHASE_SHIFT = 29;
  localparam logic [27:0] PHASE_M3 = 28'(((64'd1 << PHASE_SHIFT) + 64'd2) / 64'd3);
  localparam logic [27:0] PHASE_M9 = 28'(((64'd1 << PHASE_SHIFT) + 64'd8) / 64'd9);

  // Final rounding shifts: Q60 product down to FRAC_BITS
  localparam int SHIFT_SINGLE = 60 - FRAC_BITS;
  localparam int SHIFT_DOUBLE = 61 - FRAC_BITS;

  localparam int OUT_MAX = 131071;
  localparam int OUT_MIN = -131072;

  // Everything one request carries down the chain
  typedef struct packed {
    logic                    vld;
    logic                    spec;
    logic                    spec_one;
    logic [ELAPSED_W-1:0]    rem;
    logic [TIME_BITS-1:0]    quo;
    logic                    neg;
    logic                    half;
    logic [3:0]              k;
    logic [29:0]             fr;
    logic [24:0]             sp;
    logic [22:0]             dq;
    logic [1:0]              quad;
    logic [29:0]             r;
    logic [29:0]             z;
    logic [30:0]             a;
    logic [30:0]             eterm;
    logic [31:0]             esum;
    logic [EP_W-1:0]         ep;
    logic [31:0]             tterm;
    logic signed [34:0]      tsum;
    logic [TP_W-1:0]         tp;
    logic [31:0]             pw;
    logic signed [35:0]      cs;
    logic signed [68:0]      core;
    logic signed [25:0]      rnd;
  } lane_t;

  // floor(rem * 2^16 / div) for div three or nine
  function automatic logic [15:0] phase_frac(input logic nine, input logic [3:0] rem);
    logic [15:0] f;
    f = '0;
    if (nine) begin
      unique case (rem)
        4'd1: f = 16'd7281;
        4'd2: f = 16'd14563;
        4'd3: f = 16'd21845;
        4'd4: f = 16'd29127;
        4'd5: f = 16'd36408;
        4'd6: f = 16'd43690;
        4'd7: f = 16'd50972;
        4'd8: f = 16'd58254;
        default: f = 16'd0;
      endcase
    end else begin
      unique case (rem)
        4'd1: f = 16'd21845;
        4'd2: f = 16'd43690;
        default: f = 16'd0;
      endcase
    end
    return f;
  endfunction

endpackage

// ----- rtl/elastic_easing_curve.sv -----
// Elastic easing curve: top level with input stage, phase set-up, cell chains and output.
// Throughput: one request per cycle; the whole chain advances while the output is free.
// Depth is set by the 16 division cells, 14 two-stage power cells and 10 three-stage trig cells.
// Reset (synchronous, rst high): curve_mode 0, duration_ticks 1, every stage empty.
module elastic_easing_curve (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [eec_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [15:0]                       cfg_wdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [15:0]                       s_tdata,   // [15:0] elapsed_ticks
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [23:0]                       m_tdata    // [17:0] eased_value, [23:18] zero
);

  localparam int TB = eec_pkg::TIME_BITS;
  localparam logic signed [17:0] X_ONE = 18'sd65536;
  localparam logic signed [69:0] ONE_SINGLE = 70'sd1 <<< 60;
  localparam logic signed [69:0] ONE_DOUBLE = 70'sd1 <<< 61;
  localparam logic signed [69:0] BIAS_SINGLE = 70'sd1 <<< (eec_pkg::SHIFT_SINGLE - 1);
  localparam logic signed [69:0] BIAS_DOUBLE = 70'sd1 <<< (eec_pkg::SHIFT_DOUBLE - 1);

  logic [1:0]  curve_mode;
  logic [15:0] duration_ticks;
  logic        en;
  logic        out_vld;
  logic [eec_pkg::VALUE_W-1:0] out_val;

  eec_pkg::lane_t st0_next;
  eec_pkg::lane_t div_lane  [0:TB];
  eec_pkg::lane_t exp_lane  [0:eec_pkg::EXP_TERMS];
  eec_pkg::lane_t trig_lane [0:eec_pkg::TRIG_TERMS];
  eec_pkg::lane_t f1, f2, f3, f4, f5, b1, b2, b3;
  eec_pkg::lane_t f1_next, f2_next, f3_next, f4_next, f5_next, b1_next, b2_next, b3_next;

  logic [15:0]        x;
  logic signed [17:0] xs;
  logic [16:0]        mag;
  logic [20:0]        t;
  logic [15:0]        tfrac;
  logic signed [26:0] s_ext;
  logic [24:0]        prodr;
  logic [24:0]        rq;
  logic [31:0]        w;
  logic signed [69:0] v;
  logic signed [69:0] vb;
  logic signed [69:0] rs;
  logic [eec_pkg::VALUE_W-1:0] res_next;

  // Hold the whole chain while a result waits
  assign en       = !out_vld || m_tready;
  assign s_tready = en;
  assign m_tvalid = out_vld;
  assign m_tdata  = {6'd0, out_val};

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      curve_mode     <= eec_pkg::CURVE_IN;
      duration_ticks <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        eec_pkg::REG_CURVE_MODE: curve_mode     <= cfg_wdata[1:0];
        eec_pkg::REG_DURATION:   duration_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input stage: flag the end points, load the remainder
  always_comb begin
    st0_next          = '0;
    st0_next.vld      = s_tvalid;
    st0_next.rem      = s_tdata;
    st0_next.spec     = (s_tdata == 16'd0) || (s_tdata >= duration_ticks);
    st0_next.spec_one = (s_tdata != 16'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_lane[0].vld <= 1'b0;
    end else if (en) begin
      div_lane[0] <= st0_next;
    end
  end

  // Progress division, one quotient bit per cell
  for (genvar gi = 0; gi < TB; gi++) begin : g_div
    eec_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .divisor (duration_ticks),
      .lane_i  (div_lane[gi]),
      .lane_o  (div_lane[gi+1])
    );
  end

  // Curve argument, exponent split and phase numerator
  always_comb begin
    f1_next      = div_lane[TB];
    x            = f1_next.quo;
    f1_next.half = (curve_mode != eec_pkg::CURVE_IN) && (curve_mode != eec_pkg::CURVE_OUT);
    if (curve_mode == eec_pkg::CURVE_IN) begin
      xs          = $signed({2'b00, x}) - X_ONE;
      f1_next.neg = 1'b1;
    end else if (curve_mode == eec_pkg::CURVE_OUT) begin
      xs          = $signed({2'b00, x});
      f1_next.neg = 1'b0;
    end else begin
      xs          = $signed({1'b0, x, 1'b0}) - X_ONE;
      f1_next.neg = xs[17];
    end
    mag   = xs[17] ? 17'(-xs) : 17'(xs);
    t     = 21'(mag) * 21'd10;
    tfrac = t[15:0];
    if (tfrac != 16'd0) begin
      f1_next.k  = t[19:16] + 4'd1;
      f1_next.fr = {16'(17'h10000 - {1'b0, tfrac}), 14'd0};
    end else begin
      f1_next.k  = t[19:16];
      f1_next.fr = '0;
    end
    // offset by div * 2^21 so the floor division works on a positive value
    s_ext = 27'(xs) * (f1_next.half ? 27'sd20 : 27'sd10)
          + (f1_next.half ? 27'sd18874368 : 27'sd6291456);
    f1_next.sp = s_ext[24:0];
  end

  // Series argument and phase quotient
  always_comb begin
    f2_next    = f1;
    f2_next.z  = 30'((60'(f1.fr) * 60'(eec_pkg::LN2_Q30)) >> eec_pkg::Q_SHIFT);
    f2_next.dq = 23'((53'(f1.sp) * 53'(f1.half ? eec_pkg::PHASE_M9 : eec_pkg::PHASE_M3))
                     >> eec_pkg::PHASE_SHIFT);
  end

  // Phase in turns from quotient and remainder, seed the power series
  always_comb begin
    f3_next       = f2;
    prodr         = 25'(f2.dq) * (f2.half ? 25'd9 : 25'd3);
    rq            = f2.sp - prodr;
    w             = {f2.dq[15:0], eec_pkg::phase_frac(f2.half, rq[3:0])};
    f3_next.quad  = w[31:30];
    f3_next.r     = w[29:0];
    f3_next.eterm = 31'(eec_pkg::Q30_ONE);
    f3_next.esum  = eec_pkg::Q30_ONE;
  end

  // Angle within the quarter turn
  always_comb begin
    f4_next   = f3;
    f4_next.a = 31'((61'(f3.r) * 61'(eec_pkg::HALFPI_Q30)) >> eec_pkg::Q_SHIFT);
  end

  // Seed the trig series: sine in odd quadrants, cosine in even
  always_comb begin
    f5_next       = f4;
    f5_next.tterm = f4.quad[0] ? {1'b0, f4.a} : eec_pkg::Q30_ONE;
    f5_next.tsum  = $signed(35'(f5_next.tterm));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1.vld <= 1'b0;
      f2.vld <= 1'b0;
      f3.vld <= 1'b0;
      f4.vld <= 1'b0;
      f5.vld <= 1'b0;
    end else if (en) begin
      f1 <= f1_next;
      f2 <= f2_next;
      f3 <= f3_next;
      f4 <= f4_next;
      f5 <= f5_next;
    end
  end

  assign exp_lane[0] = f5;

  // Power-of-two series chain
  for (genvar gi = 0; gi < eec_pkg::EXP_TERMS; gi++) begin : g_exp
    eec_exp_cell #(
      .TERM_N (gi + 1)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .lane_i (exp_lane[gi]),
      .lane_o (exp_lane[gi+1])
    );
  end

  assign trig_lane[0] = exp_lane[eec_pkg::EXP_TERMS];

  // Sine / cosine series chain
  for (genvar gi = 0; gi < eec_pkg::TRIG_TERMS; gi++) begin : g_trig
    eec_trig_cell #(
      .STEP (gi + 1)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .lane_i (trig_lane[gi]),
      .lane_o (trig_lane[gi+1])
    );
  end

  // Apply the integer part of the exponent and the quadrant sign
  always_comb begin
    b1_next    = trig_lane[eec_pkg::TRIG_TERMS];
    b1_next.pw = b1_next.esum >> b1_next.k;
    if (b1_next.quad[0] ^ b1_next.quad[1]) begin
      b1_next.cs = -36'(b1_next.tsum);
    end else begin
      b1_next.cs = 36'(b1_next.tsum);
    end
  end

  // Envelope times oscillation
  always_comb begin
    b2_next      = b1;
    b2_next.core = 69'($signed({1'b0, b1.pw})) * 69'(b1.cs);
  end

  // Reflect for ease-out and the upper half of ease-in-out, round half up to the output scale
  always_comb begin
    b3_next = b2;
    if (b2.neg) begin
      v = 70'(b2.core);
    end else begin
      v = (b2.half ? ONE_DOUBLE : ONE_SINGLE) - 70'(b2.core);
    end
    vb = v + (b2.half ? BIAS_DOUBLE : BIAS_SINGLE);
    rs = b2.half ? (vb >>> eec_pkg::SHIFT_DOUBLE) : (vb >>> eec_pkg::SHIFT_SINGLE);
    b3_next.rnd = rs[25:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1.vld <= 1'b0;
      b2.vld <= 1'b0;
      b3.vld <= 1'b0;
    end else if (en) begin
      b1 <= b1_next;
      b2 <= b2_next;
      b3 <= b3_next;
    end
  end

  // Saturate, or take the end-point value
  always_comb begin
    priority if (b3.spec) begin
      res_next = b3.spec_one ? 18'd65536 : 18'd0;
    end else if (b3.rnd > 26'(eec_pkg::OUT_MAX)) begin
      res_next = 18'(eec_pkg::OUT_MAX);
    end else if (b3.rnd < 26'(eec_pkg::OUT_MIN)) begin
      res_next = 18'(eec_pkg::OUT_MIN);
    end else begin
      res_next = b3.rnd[17:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= b3.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_val <= res_next;
    end
  end

endmodule

// ----- rtl/eec_div_cell.sv -----
// One restoring-division cell: yields one quotient bit of the progress.
module eec_div_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic [eec_pkg::ELAPSED_W-1:0]   divisor,
  input  eec_pkg::lane_t                  lane_i,
  output eec_pkg::lane_t                  lane_o
);

  logic [eec_pkg::ELAPSED_W:0] rem2;
  logic                        fit;
  eec_pkg::lane_t              lane_next;

  // Shift the remainder, subtract the divisor where it fits
  always_comb begin
    lane_next = lane_i;
    rem2      = {lane_i.rem, 1'b0};
    fit       = (rem2 >= {1'b0, divisor});
    if (fit) begin
      lane_next.rem = eec_pkg::ELAPSED_W'(rem2 - {1'b0, divisor});
    end else begin
      lane_next.rem = rem2[eec_pkg::ELAPSED_W-1:0];
    end
    lane_next.quo = {lane_i.quo[eec_pkg::TIME_BITS-2:0], fit};
  end

  // Advance
  always_ff @(posedge clk) begin
    if (rst) begin
      lane_o.vld <= 1'b0;
    end else if (en) begin
      lane_o <= lane_next;
    end
  end

endmodule

// ----- rtl/eec_exp_cell.sv -----
// One term of the power-of-two series: multiply by z, then divide by the term number.
module eec_exp_cell #(
  parameter int TERM_N = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  eec_pkg::lane_t lane_i,
  output eec_pkg::lane_t lane_o
);

  localparam int PW = eec_pkg::EP_W;
  localparam int L  = $clog2(TERM_N);
  localparam int MW = PW + L + 1;
  localparam logic [63:0] M_DIV =
    ((64'd1 << (PW + L)) + 64'(TERM_N) - 64'd1) / 64'(TERM_N);

  eec_pkg::lane_t   s1, s1_next, s2_next;
  logic [PW+MW-1:0] prod;
  logic [PW-1:0]    q;

  // Term times z
  always_comb begin
    s1_next    = lane_i;
    s1_next.ep = PW'((61'(lane_i.eterm) * 61'(lane_i.z)) >> eec_pkg::Q_SHIFT);
  end

  // Divide by the term number through its reciprocal, accumulate
  always_comb begin
    s2_next       = s1;
    prod          = (PW+MW)'(s1.ep) * (PW+MW)'(MW'(M_DIV));
    q             = PW'(prod >> (PW + L));
    s2_next.eterm = 31'(q);
    s2_next.esum  = s1.esum + 32'(q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.vld     <= 1'b0;
      lane_o.vld <= 1'b0;
    end else if (en) begin
      s1     <= s1_next;
      lane_o <= s2_next;
    end
  end

endmodule

// ----- rtl/eec_trig_cell.sv -----
// One term of the sine or cosine series: two multiplies by the angle, one divide.
module eec_trig_cell #(
  parameter int STEP = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  eec_pkg::lane_t lane_i,
  output eec_pkg::lane_t lane_o
);

  localparam int PW       = eec_pkg::TP_W;
  localparam int DIV_ODD  = (2 * STEP) * (2 * STEP + 1);
  localparam int DIV_EVEN = (2 * STEP - 1) * (2 * STEP);
  localparam bit NEG      = (STEP % 2) == 1;
  localparam int L        = $clog2(DIV_ODD);
  localparam int MW       = PW + L + 1;
  localparam logic [63:0] M_ODD =
    ((64'd1 << (PW + L)) + 64'(DIV_ODD) - 64'd1) / 64'(DIV_ODD);
  localparam logic [63:0] M_EVEN =
    ((64'd1 << (PW + L)) + 64'(DIV_EVEN) - 64'd1) / 64'(DIV_EVEN);

  eec_pkg::lane_t   s1, s2, s1_next, s2_next, s3_next;
  logic [PW+MW-1:0] prod_odd;
  logic [PW+MW-1:0] prod_even;
  logic [PW-1:0]    q;

  // First multiply by the angle
  always_comb begin
    s1_next    = lane_i;
    s1_next.tp = PW'((63'(lane_i.tterm) * 63'(lane_i.a)) >> eec_pkg::Q_SHIFT);
  end

  // Second multiply by the angle
  always_comb begin
    s2_next    = s1;
    s2_next.tp = PW'((65'(s1.tp) * 65'(s1.a)) >> eec_pkg::Q_SHIFT);
  end

  // Divide by (n-1)n, sine or cosine set by the quadrant, and accumulate
  always_comb begin
    s3_next       = s2;
    prod_odd      = (PW+MW)'(s2.tp) * (PW+MW)'(MW'(M_ODD));
    prod_even     = (PW+MW)'(s2.tp) * (PW+MW)'(MW'(M_EVEN));
    q             = s2.quad[0] ? PW'(prod_odd >> (PW + L)) : PW'(prod_even >> (PW + L));
    s3_next.tterm = 32'(q);
    if (NEG) begin
      s3_next.tsum = s2.tsum - $signed({1'b0, q});
    end else begin
      s3_next.tsum = s2.tsum + $signed({1'b0, q});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.vld     <= 1'b0;
      s2.vld     <= 1'b0;
      lane_o.vld <= 1'b0;
    end else if (en) begin
      s1     <= s1_next;
      s2     <= s2_next;
      lane_o <= s3_next;
    end
  end

endmodule

// ----- tb/tb_elastic_easing_curve.sv -----
// Self-checking testbench for the elastic easing curve block.
`timescale 1ns / 1ps

class easing_scoreboard;
  logic [1:0]  mode;
  logic [15:0] duration;
  logic signed [17:0] pending[$];
  int errors;

  function new();
    mode = eec_pkg::CURVE_IN;
    duration = 16'd1;
    errors = 0;
  endfunction

  // round v / 2^s half up
  function automatic longint round_half_up(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  // 2^y for y <= 0 with 32 fraction bits, Q30
  function automatic longint pow2_q30(longint y);
    logic [63:0] m, k, fr, z, term, total;
    m = 64'd0 - y;
    k = m >> 32;
    fr = m & 64'hFFFF_FFFF;
    term = 64'd1 << 30;
    total = term;
    if (fr != 0) begin
      k++;
      fr = (64'd1 << 32) - fr;
    end
    z = ((fr >> 2) * 64'd744261118) >> 30;
    for (int n = 1; n <= 14; n++) begin
      term = ((term * z) >> 30) / n;
      total += term;
    end
    if (k > 40) return 0;
    return longint'(total >> k);
  endfunction

  // quarter-turn sine (odd) or cosine series, Q30
  function automatic longint trig_q30(logic [63:0] a, bit odd);
    logic [63:0] term;
    longint total;
    int n;
    bit neg;
    term = odd ? a : (64'd1 << 30);
    total = longint'(term);
    n = odd ? 1 : 0;
    neg = 1;
    for (int i = 0; i < 10; i++) begin
      n += 2;
      term = (((term * a) >> 30) * a) >> 30;
      term = term / ((n - 1) * n);
      total += neg ? -longint'(term) : longint'(term);
      neg = !neg;
    end
    return total;
  endfunction

  // cos(2 pi u mul / div), floored phase in turns
  function automatic longint cos_q30(longint u, longint mul, longint dv);
    longint num, q;
    logic [31:0] w;
    logic [63:0] a;
    num = u * mul;
    q = num / dv;
    if (num % dv != 0 && num < 0) q--;
    w = q[31:0];
    a = ({34'd0, w[29:0]} * 64'd1686629713) >> 30;
    case (w[31:30])
      2'd0: return trig_q30(a, 0);
      2'd1: return -trig_q30(a, 1);
      2'd2: return -trig_q30(a, 0);
      default: return trig_q30(a, 1);
    endcase
  endfunction

  function automatic logic signed [17:0] eased(logic [15:0] e);
    longint res, x, u, core;
    if (e == 0) res = 0;
    else if (e >= duration) res = 1 << 16;
    else begin
      x = longint'((64'(e) << 16) / duration);
      if (mode == eec_pkg::CURVE_IN) begin
        u = (x - 65536) * 65536;
        core = pow2_q30(10 * u) * cos_q30(u, 10, 3);
        res = round_half_up(core, 44);
      end else if (mode == eec_pkg::CURVE_OUT) begin
        u = x * 65536;
        core = pow2_q30(-10 * u) * cos_q30(u, 10, 3);
        res = round_half_up((longint'(1) << 60) - core, 44);
      end else begin
        u = (2 * x - 65536) * 65536;
        if (u < 0) begin
          core = pow2_q30(10 * u) * cos_q30(u, 20, 9);
          res = round_half_up(core, 45);
        end else begin
          core = pow2_q30(-10 * u) * cos_q30(u, 20, 9);
          res = round_half_up((longint'(1) << 61) - core, 45);
        end
      end
    end
    if (res > 131071) res = 131071;
    if (res < -131072) res = -131072;
    return res[17:0];
  endfunction

  function void note_request(logic [15:0] e);
    pending.push_back(eased(e));
  endfunction

  function void check_result(logic [23:0] data);
    logic signed [17:0] want;
    if (pending.size() == 0) begin
      $error("eased_value: unexpected result %0d", $signed(data[17:0]));
      errors++;
      return;
    end
    want = pending.pop_front();
    if (data[17:0] !== want) begin
      $error("eased_value: expected %0d, actual %0d", want, $signed(data[17:0]));
      errors++;
    end
    if (data[23:18] !== 6'd0) begin
      $error("pad: expected 0, actual %0h", data[23:18]);
      errors++;
    end
  endfunction
endclass

module tb_elastic_easing_curve;

  localparam int LATENCY = 84;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [eec_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  logic s_tvalid = 0;
  logic s_tready;
  logic [15:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [23:0] m_tdata;

  int idle_pct = 0;
  int stall_pct = 0;
  easing_scoreboard sb = new();

  elastic_easing_curve DUT (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // Check every accepted result and every accepted request
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
    if (!rst && s_tvalid && s_tready) sb.note_request(s_tdata);
  end

  // Receiver stalls
  always @(posedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

  task automatic write_reg(logic [eec_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == eec_pkg::REG_CURVE_MODE) sb.mode = val[1:0];
    else sb.duration = val;
  endtask

  // Send one request, holding until accepted
  task automatic send_request(logic [15:0] e);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= e;
    do @(posedge clk); while (!s_tready);
  endtask

  // Drain the pipeline before touching registers
  task automatic drain();
    int guard;
    s_tvalid <= 0;
    guard = 0;
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  function automatic logic [15:0] random_elapsed(logic [15:0] d);
    case ($urandom_range(9))
      0: return 16'($urandom);
      1: return 16'($urandom_range(3));
      2: return d;
      3: return 16'($urandom_range(d + 32, d > 32 ? d - 32 : 0));
      default: return 16'($urandom_range(d, 0));
    endcase
  endfunction

  initial begin
    logic [15:0] durations[8] = '{16'd1, 16'd65535, 16'd3, 16'd100, 16'd1000,
                                  16'd0, 16'd40000, 16'd7};
    logic [15:0] corners[9] = '{16'd0, 16'd1, 16'd2, 16'h7FFF, 16'h8000, 16'hAAAA,
                                16'h5555, 16'hFFFE, 16'hFFFF};
    logic [15:0] dur;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: reset settings, then the extremes in every mode
    send_request(16'd0);
    send_request(16'd1);
    send_request(16'hFFFF);
    drain();
    write_reg(eec_pkg::REG_DURATION, 16'hFFFF);
    for (int m = 0; m < 4; m++) begin
      drain();
      write_reg(eec_pkg::REG_CURVE_MODE, 16'(m));
      foreach (corners[i])
        send_request(corners[i]);
    end

    // Random phases over modes, durations and idling patterns
    for (int ph = 0; ph < 16; ph++) begin
      drain();
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 68; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 68; end
        default: begin idle_pct = 8; stall_pct = 8; end
      endcase
      dur = (ph < 8) ? durations[ph] : 16'($urandom_range(65535, 1));
      write_reg(eec_pkg::REG_CURVE_MODE, 16'((ph / 4 + ph) % 4));
      write_reg(eec_pkg::REG_DURATION, dur);
      for (int i = 0; i < 118; i++) send_request(random_elapsed(dur));
    end

    drain();
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Timeout
  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// ----- elastic_easing_curve.f -----
rtl/eec_pkg.sv
rtl/eec_div_cell.sv
rtl/eec_exp_cell.sv
rtl/eec_trig_cell.sv
rtl/elastic_easing_curve.sv
tb/tb_elastic_easing_curve.sv
